/* rtl/core/urmf_pkg.sv */
// shared types and constants for the ultrasonic range median filter
`timescale 1ns / 1ps

package urmf_pkg;

    // field widths
    localparam int ECHO_W = 15;
    localparam int DIST_W = 16;
    localparam int KEY_W  = DIST_W + 1;
    localparam int SUM_W  = 19;
    localparam int MUL_W  = 17;
    localparam int PROD_W = ECHO_W + MUL_W;

    // echo time to distance: 0.0343 / 2 * 64 in 1.16 fixed point, round half up
    localparam logic [MUL_W-1:0]  DIST_MUL   = 17'd71932;
    localparam int                DIST_SHIFT = 16;
    localparam logic [PROD_W-1:0] DIST_ROUND = PROD_W'(1) << (DIST_SHIFT - 1);

    // default range limit, 80 cm
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 16'd5120;

    // history ring
    localparam int                SLOTS     = 3;
    localparam int                SLOT_W    = 2;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    // calibration sequence
    localparam int           CNT_W       = 4;
    localparam int           PRIME_W     = 2;
    localparam logic [CNT_W-1:0]   CAL_SAMPLES = 4'd10;
    localparam logic [CNT_W-1:0]   CAL_LAST    = 4'd9;
    localparam logic [PRIME_W-1:0] PRIME_LAST  = 2'd2;
    localparam logic [SUM_W-1:0]   TRIM_ROUND  = 19'd4;
    localparam int                 TRIM_SHIFT  = 3;

    // item kind
    typedef enum logic {
        KIND_MEASURE = 1'b0,
        KIND_CAL     = 1'b1
    } kind_t;

    // converted reading handed from the conversion stage to the filter stage
    typedef struct packed {
        kind_t             kind;
        logic [DIST_W-1:0] distance;
        logic              ok;
    } conv_word_t;

endpackage

/* rtl/core/urmf_convert.sv */
// input register and echo time to distance conversion stage
`timescale 1ns / 1ps

module urmf_convert
    import urmf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DIST_W-1:0] max_distance,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [ECHO_W-1:0] s_echo_us,
    output logic              cv_valid,
    input  logic              cv_ready,
    output conv_word_t        cv_word
);

    logic              in_valid_reg, in_valid_next;
    kind_t             in_kind_reg;
    logic [ECHO_W-1:0] in_echo_reg;
    logic              cv_valid_reg, cv_valid_next;
    conv_word_t        cv_word_reg, cv_word_next;
    logic              cv_en;
    logic              in_en;
    logic [PROD_W-1:0] prod;
    logic [DIST_W-1:0] scaled_dist;

    // stage enables, each stage moves when the one after it has room
    assign cv_en   = !cv_valid_reg || cv_ready;
    assign in_en   = !in_valid_reg || cv_en;
    assign s_ready = in_en;

    assign in_valid_next = in_en ? s_valid : in_valid_reg;
    assign cv_valid_next = cv_en ? in_valid_reg : cv_valid_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && in_en) begin
            in_kind_reg <= kind_t'(s_kind);
            in_echo_reg <= s_echo_us;
        end
    end

    // scale and round, then range check
    always_comb begin
        prod = PROD_W'(in_echo_reg) * PROD_W'(DIST_MUL) + DIST_ROUND;
        scaled_dist = prod[PROD_W-1:DIST_SHIFT];
        cv_word_next.kind = in_kind_reg;
        cv_word_next.ok   = (in_echo_reg != '0) && (scaled_dist != '0) &&
                            (scaled_dist <= max_distance);
        cv_word_next.distance = cv_word_next.ok ? scaled_dist : '0;
    end

    // conversion register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_valid_reg <= 1'b0;
        end else begin
            cv_valid_reg <= cv_valid_next;
        end
        if (in_valid_reg && cv_en) begin
            cv_word_reg <= cv_word_next;
        end
    end

    assign cv_valid = cv_valid_reg;
    assign cv_word  = cv_word_reg;

endmodule

/* rtl/core/urmf_filter.sv */
// median-of-three history, calibration state and result register
`timescale 1ns / 1ps

module urmf_filter
    import urmf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cv_valid,
    output logic              cv_ready,
    input  conv_word_t        cv_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DIST_W-1:0] m_distance,
    output logic              m_distance_valid,
    output logic [DIST_W-1:0] m_baseline,
    output logic              m_baseline_valid
);

    // history ring
    logic                slot_full_reg [SLOTS];
    logic                slot_full_next[SLOTS];
    logic [DIST_W-1:0]   slot_val_reg  [SLOTS];
    logic [DIST_W-1:0]   slot_val_next [SLOTS];
    logic [SLOT_W-1:0]   write_slot_reg, write_slot_next;
    logic                filter_ready_reg, filter_ready_next;

    // calibration state
    logic [CNT_W-1:0]    cal_count_reg, cal_count_next;
    logic [PRIME_W-1:0]  prime_count_reg, prime_count_next;
    logic [DIST_W-1:0]   cal_min_reg, cal_min_next;
    logic [DIST_W-1:0]   cal_max_reg, cal_max_next;
    logic [SUM_W-1:0]    cal_sum_reg, cal_sum_next;
    logic [DIST_W-1:0]   baseline_reg, baseline_next;
    logic                baseline_ok_reg, baseline_ok_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic                out_dist_ok_reg, out_dist_ok_next;

    logic                advance;
    logic                store_en;
    logic                wrap;
    logic                collecting;
    logic [KEY_W-1:0]    key[SLOTS];
    logic [KEY_W-1:0]    med_key;
    logic                gt_ab, gt_bc, gt_ac;
    logic [SUM_W-1:0]    trimmed;

    assign cv_ready = !out_valid_reg || m_ready;
    assign advance  = cv_valid && cv_ready;

    assign wrap       = (write_slot_reg == SLOT_LAST);
    assign collecting = (cal_count_reg < CAL_SAMPLES);
    assign store_en   = cv_word.ok &&
                        ((cv_word.kind == KIND_MEASURE) || !collecting);

    // ring write and slot keys, empty slots sort lowest
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (store_en && (write_slot_reg == SLOT_W'(i))) begin
                slot_full_next[i] = 1'b1;
                slot_val_next[i]  = cv_word.distance;
            end else begin
                slot_full_next[i] = slot_full_reg[i];
                slot_val_next[i]  = slot_val_reg[i];
            end
            key[i] = slot_full_next[i] ? ({1'b0, slot_val_next[i]} + KEY_W'(1)) : '0;
        end
        if (store_en) begin
            write_slot_next = wrap ? '0 : write_slot_reg + SLOT_W'(1);
        end else begin
            write_slot_next = write_slot_reg;
        end
    end

    // median of three from three parallel compares
    always_comb begin
        gt_ab = key[0] > key[1];
        gt_bc = key[1] > key[2];
        gt_ac = key[0] > key[2];
        if (gt_ab) begin
            med_key = gt_bc ? key[1] : (gt_ac ? key[2] : key[0]);
        end else begin
            med_key = gt_ac ? key[0] : (gt_bc ? key[2] : key[1]);
        end
    end

    // measure, calibrate and prime handling
    always_comb begin
        filter_ready_next = filter_ready_reg;
        cal_count_next    = cal_count_reg;
        prime_count_next  = prime_count_reg;
        cal_min_next      = cal_min_reg;
        cal_max_next      = cal_max_reg;
        cal_sum_next      = cal_sum_reg;
        baseline_next     = baseline_reg;
        baseline_ok_next  = baseline_ok_reg;
        out_dist_next     = '0;
        out_dist_ok_next  = 1'b0;
        trimmed           = '0;

        case (cv_word.kind)
            KIND_MEASURE: begin
                if (cv_word.ok) begin
                    if (!filter_ready_reg && !wrap) begin
                        out_dist_next    = cv_word.distance;
                        out_dist_ok_next = 1'b1;
                    end else begin
                        filter_ready_next = 1'b1;
                        if (med_key != '0) begin
                            out_dist_next    = DIST_W'(med_key - KEY_W'(1));
                            out_dist_ok_next = 1'b1;
                        end
                    end
                end
            end
            KIND_CAL: begin
                out_dist_next    = cv_word.distance;
                out_dist_ok_next = cv_word.ok;
                if (collecting) begin
                    if (cv_word.ok) begin
                        // sample statistics
                        if (cal_count_reg == '0) begin
                            cal_min_next = cv_word.distance;
                            cal_max_next = cv_word.distance;
                            cal_sum_next = SUM_W'(cv_word.distance);
                        end else begin
                            if (cv_word.distance < cal_min_reg) begin
                                cal_min_next = cv_word.distance;
                            end
                            if (cv_word.distance > cal_max_reg) begin
                                cal_max_next = cv_word.distance;
                            end
                            cal_sum_next = cal_sum_reg + SUM_W'(cv_word.distance);
                        end
                        cal_count_next = cal_count_reg + CNT_W'(1);
                        // trimmed mean on the tenth sample
                        if (cal_count_reg == CAL_LAST) begin
                            trimmed = cal_sum_next - SUM_W'(cal_min_next)
                                      - SUM_W'(cal_max_next) + TRIM_ROUND;
                            baseline_next    = trimmed[TRIM_SHIFT +: DIST_W];
                            baseline_ok_next = 1'b1;
                            prime_count_next = '0;
                        end
                    end
                end else begin
                    // priming items count whether valid or not
                    if (prime_count_reg == PRIME_LAST) begin
                        filter_ready_next = 1'b1;
                        prime_count_next  = '0;
                        cal_count_next    = '0;
                    end else begin
                        prime_count_next = prime_count_reg + PRIME_W'(1);
                    end
                end
            end
            default: begin
                out_dist_next    = '0;
                out_dist_ok_next = 1'b0;
            end
        endcase
    end

    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // state update on each word taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_full_reg[i] <= 1'b0;
            end
            write_slot_reg   <= '0;
            filter_ready_reg <= 1'b0;
            cal_count_reg    <= '0;
            prime_count_reg  <= '0;
            cal_min_reg      <= '0;
            cal_max_reg      <= '0;
            cal_sum_reg      <= '0;
            baseline_reg     <= '0;
            baseline_ok_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_full_reg[i] <= slot_full_next[i];
                end
                write_slot_reg   <= write_slot_next;
                filter_ready_reg <= filter_ready_next;
                cal_count_reg    <= cal_count_next;
                prime_count_reg  <= prime_count_next;
                cal_min_reg      <= cal_min_next;
                cal_max_reg      <= cal_max_next;
                cal_sum_reg      <= cal_sum_next;
                baseline_reg     <= baseline_next;
                baseline_ok_reg  <= baseline_ok_next;
            end
        end
        if (advance) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_val_reg[i] <= slot_val_next[i];
            end
            out_dist_reg    <= out_dist_next;
            out_dist_ok_reg <= out_dist_ok_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_distance       = out_dist_reg;
    assign m_distance_valid = out_dist_ok_reg;
    assign m_baseline       = baseline_reg;
    assign m_baseline_valid = baseline_ok_reg;

    // priming only runs once ten samples are in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (prime_count_reg != '0) |-> (cal_count_reg == CAL_SAMPLES))
        else $error("priming count set outside the priming phase");

    // a calibration, once done, is never lost
    assert property (@(posedge aclk) disable iff (!aresetn)
        baseline_ok_reg |=> baseline_ok_reg)
        else $error("baseline valid dropped");

    // ring state only moves when a word is taken into the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> ($stable(write_slot_reg) && $stable(cal_count_reg)))
        else $error("filter state changed while result stalled");

    // an invalid result carries a zero distance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_dist_ok_reg) |-> (out_dist_reg == '0))
        else $error("invalid result with nonzero distance");

endmodule

/* rtl/core/ultrasonic_range_median_filter.sv */
// top level of the ultrasonic range median filter
//
//  port group   direction  handshake          payload
//  s_           in         s_valid/s_ready    s_kind, s_echo_us
//  m_           out        m_valid/m_ready    m_distance, m_distance_valid,
//                                             m_baseline, m_baseline_valid
//  cfg_         in         cfg_wr_en          cfg_wr_data (max_distance)
//
// one word accepted per cycle unless an m_ready stall has filled the pipeline; each word gives exactly one result word
// a word passes through the input register, the conversion register (the one
// 15 x 17 multiplier) and the result register
// aresetn is synchronous, active low; it empties the pipeline and history
// ring and restores the range limit to 80 cm
// a stall on m_ready holds every stage; s_ready drops only when all are full
`timescale 1ns / 1ps

module ultrasonic_range_median_filter
    import urmf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [DIST_W-1:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [ECHO_W-1:0] s_echo_us,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DIST_W-1:0] m_distance,
    output logic              m_distance_valid,
    output logic [DIST_W-1:0] m_baseline,
    output logic              m_baseline_valid
);

    logic [DIST_W-1:0] max_distance_reg;
    logic              cv_valid;
    logic              cv_ready;
    conv_word_t        cv_word;

    // range limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_distance_reg <= MAX_DISTANCE_RESET;
        end else if (cfg_wr_en) begin
            max_distance_reg <= cfg_wr_data;
        end
    end

    // input and conversion stages
    urmf_convert u_convert (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .max_distance (max_distance_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_echo_us    (s_echo_us),
        .cv_valid     (cv_valid),
        .cv_ready     (cv_ready),
        .cv_word      (cv_word)
    );

    // filter, calibration and result register
    urmf_filter u_filter (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cv_valid         (cv_valid),
        .cv_ready         (cv_ready),
        .cv_word          (cv_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distance       (m_distance),
        .m_distance_valid (m_distance_valid),
        .m_baseline       (m_baseline),
        .m_baseline_valid (m_baseline_valid)
    );

endmodule

/* dv/ultrasonic_range_median_filter_test.sv */
// self-checking testbench for the ultrasonic range median filter
`timescale 1ns / 1ps

module ultrasonic_range_median_filter_test;
    import urmf_pkg::*;

    localparam int          CLK_HALF        = 4;
    localparam int          RESET_CYCLES    = 11;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          MAX_GAP         = 8;
    localparam int          PRESSURE_AT     = 400;
    localparam int          PRESSURE_CYCLES = 64;
    localparam int          DIRECTED_ROWS   = 25;
    localparam int          PHASES          = 6;
    localparam int          ECHO_CEIL       = 30000;
    localparam int          CAL_NEEDED      = 10;
    localparam int          PRIME_NEEDED    = 3;
    localparam int          RING_LAST       = 2;
    localparam logic [31:0] ECHO_SCALE      = 32'd71932;
    localparam logic [31:0] HALF_LSB        = 32'h8000;
    localparam logic [15:0] LIMIT_AT_RESET  = 16'd5120;
    localparam logic [15:0] LIMIT_TOP       = 16'd32928;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              distance_ok;
        logic [DIST_W-1:0] baseline;
        logic              baseline_ok;
    } range_result_t;

    typedef struct packed {
        kind_t             kind;
        logic [ECHO_W-1:0] echo;
        logic              typed;
        range_result_t     want;
    } stim_row_t;

    localparam range_result_t UNTYPED = '0;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [DIST_W-1:0] cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_kind;
    logic [ECHO_W-1:0] s_echo_us;
    logic              m_valid;
    logic              m_ready;
    logic [DIST_W-1:0] m_distance;
    logic              m_distance_valid;
    logic [DIST_W-1:0] m_baseline;
    logic              m_baseline_valid;

    // predicted state of the filter
    logic [DIST_W-1:0] lim_distance;
    logic              ring_full [3];
    logic [DIST_W-1:0] ring_val [3];
    int                ring_wr;
    logic              ring_ready;
    int                cal_seen;
    int                prime_seen;
    logic [DIST_W-1:0] cal_lo;
    logic [DIST_W-1:0] cal_hi;
    logic [SUM_W-1:0]  cal_acc;
    logic [DIST_W-1:0] base_value;
    logic              base_ok;

    range_result_t expected_ranges [$];
    stim_row_t     directed_rows [DIRECTED_ROWS];

    int   words_sent;
    int   results_seen = 0;
    int   error_count = 0;
    int   cal_done_count;
    int   phases_run;
    int   cycle_count = 0;
    logic quiet_idle;

    ultrasonic_range_median_filter u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_echo_us        (s_echo_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_distance       (m_distance),
        .m_distance_valid (m_distance_valid),
        .m_baseline       (m_baseline),
        .m_baseline_valid (m_baseline_valid)
    );

    // clock
    initial begin : clock_gen
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // run-length guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ultrasonic_range_median_filter_test: done, errors");
        $finish;
    end

    function automatic void reset_predictor();
        lim_distance = LIMIT_AT_RESET;
        for (int i = 0; i < 3; i++) begin
            ring_full[i] = 1'b0;
            ring_val[i]  = '0;
        end
        ring_wr    = 0;
        ring_ready = 1'b0;
        cal_seen   = 0;
        prime_seen = 0;
        cal_lo     = '0;
        cal_hi     = '0;
        cal_acc    = '0;
        base_value = '0;
        base_ok    = 1'b0;
    endfunction

    // echo time to 1/64 cm, rounded half up, checked against the range limit
    function automatic logic [DIST_W-1:0] echo_to_distance(input logic [ECHO_W-1:0] echo,
                                                          output logic ok);
        logic [31:0] scaled;
        scaled = 32'(echo) * ECHO_SCALE + HALF_LSB;
        ok = (echo != '0) && (scaled[31:16] != '0) && (scaled[31:16] <= lim_distance);
        return ok ? scaled[31:16] : '0;
    endfunction

    // write into the history ring; a wrap marks the filter ready only for measure words
    function automatic void push_history(input logic [DIST_W-1:0] d, input logic mark_ready);
        ring_full[ring_wr] = 1'b1;
        ring_val[ring_wr]  = d;
        if (ring_wr == RING_LAST) begin
            ring_wr = 0;
            if (mark_ready) ring_ready = 1'b1;
        end else begin
            ring_wr = ring_wr + 1;
        end
    endfunction

    // empty slots sort below every reading, so key 0 means an empty median
    function automatic logic [DIST_W:0] history_median_key();
        logic [DIST_W:0] k [3];
        logic [DIST_W:0] t;
        for (int i = 0; i < 3; i++) begin
            k[i] = ring_full[i] ? {1'b0, ring_val[i]} + 1'b1 : '0;
        end
        if (k[0] > k[1]) begin t = k[0]; k[0] = k[1]; k[1] = t; end
        if (k[1] > k[2]) begin t = k[1]; k[1] = k[2]; k[2] = t; end
        if (k[0] > k[1]) begin t = k[0]; k[0] = k[1]; k[1] = t; end
        return k[1];
    endfunction

    function automatic range_result_t predict_range(input kind_t kind,
                                                    input logic [ECHO_W-1:0] echo);
        range_result_t     res;
        logic [DIST_W-1:0] d;
        logic              ok;
        logic [DIST_W:0]   key;
        logic [31:0]       trimmed;
        res = '0;
        d   = echo_to_distance(echo, ok);
        if (kind == KIND_MEASURE) begin
            if (ok) begin
                push_history(d, 1'b1);
                if (!ring_ready) begin
                    res.distance    = d;
                    res.distance_ok = 1'b1;
                end else begin
                    key = history_median_key();
                    if (key != '0) begin
                        res.distance    = DIST_W'(key - 1'b1);
                        res.distance_ok = 1'b1;
                    end
                end
            end
        end else begin
            res.distance    = d;
            res.distance_ok = ok;
            if (cal_seen < CAL_NEEDED) begin
                // collect samples, invalid ones skipped
                if (ok) begin
                    if (cal_seen == 0) begin
                        cal_lo  = d;
                        cal_hi  = d;
                        cal_acc = SUM_W'(d);
                    end else begin
                        if (d < cal_lo) cal_lo = d;
                        if (d > cal_hi) cal_hi = d;
                        cal_acc = cal_acc + SUM_W'(d);
                    end
                    cal_seen++;
                    if (cal_seen == CAL_NEEDED) begin
                        // drop min and max, mean of eight, rounded half up
                        trimmed    = 32'(cal_acc) - 32'(cal_lo) - 32'(cal_hi) + 32'd4;
                        base_value = DIST_W'(trimmed >> 3);
                        base_ok    = 1'b1;
                        prime_seen = 0;
                        cal_done_count++;
                    end
                end
            end else begin
                // priming words count whether valid or not
                if (ok) push_history(d, 1'b0);
                prime_seen++;
                if (prime_seen >= PRIME_NEEDED) begin
                    ring_ready = 1'b1;
                    prime_seen = 0;
                    cal_seen   = 0;
                end
            end
        end
        res.baseline    = base_value;
        res.baseline_ok = base_ok;
        return res;
    endfunction

    function automatic int draw_gap();
        if (quiet_idle) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // mostly readings inside the range limit, with edges, timeouts and over-range mixed in
    function automatic logic [ECHO_W-1:0] draw_echo();
        int top;
        int pick;
        int echo;
        top = int'((longint'(lim_distance) << 16) / longint'(ECHO_SCALE));
        if (top < 1) top = 1;
        if (top > ECHO_CEIL) top = ECHO_CEIL;
        pick = $urandom_range(0, 99);
        if (pick < 8) echo = 0;
        else if (pick < 16) echo = $urandom_range(0, ECHO_CEIL);
        else if (pick < 22) echo = top;
        else if (pick < 28) echo = (top < ECHO_CEIL) ? top + 1 : top;
        else if (pick < 32) echo = 1;
        else echo = $urandom_range(1, top);
        return ECHO_W'(echo);
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // offer one word, record its prediction when it is taken
    task automatic send_word(input kind_t kind, input logic [ECHO_W-1:0] echo,
                             input logic typed, input range_result_t want);
        int            gap;
        range_result_t pred;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_echo_us <= echo;
        do @(posedge aclk); while (!s_ready);
        pred = predict_range(kind, echo);
        expected_ranges.push_back(typed ? want : pred);
        words_sent++;
        @(negedge aclk);
    endtask

    // wait until every result is back, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_ranges.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [DIST_W-1:0] limit);
        cfg_wr_data <= limit;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        lim_distance = limit;
        phases_run++;
    endtask

    // random words: calibration runs with random content, measure words, some noise
    task automatic run_random_phase(input logic [DIST_W-1:0] limit, input int words,
                                    input logic quiet);
        int    cal_left;
        kind_t kind;
        cal_left = 0;
        write_limit(limit);
        quiet_idle = quiet;
        repeat (words) begin
            if (cal_left == 0 && $urandom_range(0, 24) == 0) begin
                cal_left = 13 + $urandom_range(0, 4);
            end
            if (cal_left != 0) begin
                kind = KIND_CAL;
                cal_left--;
            end else begin
                kind = ($urandom_range(0, 9) == 0) ? KIND_CAL : KIND_MEASURE;
            end
            send_word(kind, draw_echo(), 1'b0, UNTYPED);
        end
        drain();
        quiet_idle = 1'b0;
    endtask

    task automatic check_result();
        range_result_t got;
        range_result_t want;
        got = {m_distance, m_distance_valid, m_baseline, m_baseline_valid};
        results_seen++;
        if (expected_ranges.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %0d/%0b %0d/%0b",
                     $time, got.distance, got.distance_ok, got.baseline, got.baseline_ok);
            error_count++;
            return;
        end
        want = expected_ranges.pop_front();
        compare_field("distance", want.distance, got.distance);
        compare_field("distance_valid", want.distance_ok, got.distance_ok);
        compare_field("baseline", want.baseline, got.baseline);
        compare_field("baseline_valid", want.baseline_ok, got.baseline_ok);
    endtask

    // result side: random hold-offs, one long one to back the pipeline up
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = (results_seen == PRESSURE_AT) ? PRESSURE_CYCLES : draw_gap();
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_result();
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [DIST_W-1:0] limits [PHASES];
        int                words [PHASES];
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_kind         = 1'b0;
        s_echo_us      = '0;
        quiet_idle     = 1'b0;
        words_sent     = 0;
        cal_done_count = 0;
        phases_run     = 0;
        reset_predictor();

        // directed words at the reset range limit of 80 cm
        directed_rows = '{
            // no echo, then over range, then an ignored calibration timeout
            '{KIND_MEASURE, 15'd0,     1'b1, '{16'd0,    1'b0, 16'd0, 1'b0}},
            '{KIND_MEASURE, 15'd30000, 1'b1, '{16'd0,    1'b0, 16'd0, 1'b0}},
            '{KIND_CAL,     15'd0,     1'b1, '{16'd0,    1'b0, 16'd0, 1'b0}},
            // smallest and largest accepted distances as calibration samples
            '{KIND_CAL,     15'd1,     1'b1, '{16'd1,    1'b1, 16'd0, 1'b0}},
            '{KIND_CAL,     15'd4665,  1'b1, '{16'd5120, 1'b1, 16'd0, 1'b0}},
            '{KIND_CAL,     15'd1000,  1'b0, UNTYPED},
            '{KIND_CAL,     15'd2000,  1'b0, UNTYPED},
            '{KIND_CAL,     15'd4666,  1'b0, UNTYPED},
            '{KIND_CAL,     15'd3000,  1'b0, UNTYPED},
            '{KIND_CAL,     15'd4000,  1'b0, UNTYPED},
            '{KIND_CAL,     15'd500,   1'b0, UNTYPED},
            '{KIND_CAL,     15'd2500,  1'b0, UNTYPED},
            '{KIND_CAL,     15'd3500,  1'b0, UNTYPED},
            '{KIND_CAL,     15'd1500,  1'b0, UNTYPED},
            // priming with no valid reading leaves the ring empty but ready
            '{KIND_CAL,     15'd0,     1'b0, UNTYPED},
            '{KIND_CAL,     15'd30000, 1'b0, UNTYPED},
            '{KIND_CAL,     15'd0,     1'b0, UNTYPED},
            // one slot full: median is an empty slot
            '{KIND_MEASURE, 15'd2000,  1'b0, UNTYPED},
            '{KIND_MEASURE, 15'd3000,  1'b0, UNTYPED},
            '{KIND_MEASURE, 15'd4666,  1'b0, UNTYPED},
            '{KIND_MEASURE, 15'd1,     1'b0, UNTYPED},
            '{KIND_MEASURE, 15'd4665,  1'b0, UNTYPED},
            // measure word in the middle of a new calibration
            '{KIND_CAL,     15'd1200,  1'b0, UNTYPED},
            '{KIND_MEASURE, 15'd800,   1'b0, UNTYPED},
            '{KIND_CAL,     15'd0,     1'b0, UNTYPED}
        };

        // range limits per phase, extremes included
        limits[0] = LIMIT_TOP;
        limits[1] = 16'd0;
        limits[2] = 16'd1;
        limits[3] = DIST_W'($urandom_range(1, LIMIT_TOP));
        limits[4] = LIMIT_AT_RESET;
        limits[5] = DIST_W'($urandom_range(1, LIMIT_TOP));
        words     = '{250, 40, 60, 300, 300, 250};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].kind, directed_rows[i].echo,
                      directed_rows[i].typed, directed_rows[i].want);
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            run_random_phase(limits[p], words[p], p == 4);
        end

        $display("covered %0d words over %0d written range limits (0, 1, 80 cm, full scale)",
                 words_sent, phases_run);
        $display("%0d calibrations completed, %0d results checked, one %0d-cycle output stall",
                 cal_done_count, results_seen, PRESSURE_CYCLES);
        if (error_count == 0) begin
            $display("ultrasonic_range_median_filter_test: done, clean");
        end else begin
            $display("ultrasonic_range_median_filter_test: done, errors");
        end
        $finish;
    end

endmodule
